FILE: rtl/sspf_pkg.sv
// Shared types, phase codes and outcome codes for the signature subpacket expiry finder.
`timescale 1ns / 1ps
`default_nettype none

package sspf_pkg;

    localparam int PosWidth = 18;
    localparam logic [PosWidth-1:0] PosMax = {PosWidth{1'b1}};

    // Parse phases of the subpacket walk.
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_LEN1    = 3'd1;
    localparam logic [2:0] PH_LEN2    = 3'd2;
    localparam logic [2:0] PH_LEN5    = 3'd3;
    localparam logic [2:0] PH_TYPE    = 3'd4;
    localparam logic [2:0] PH_BODY    = 3'd5;
    localparam logic [2:0] PH_CAPTURE = 3'd6;
    localparam logic [2:0] PH_DONE    = 3'd7;

    // Result outcome codes.
    localparam logic [2:0] OUT_FOUND     = 3'd0;
    localparam logic [2:0] OUT_NOT_FOUND = 3'd1;
    localparam logic [2:0] OUT_BAD_VER   = 3'd2;
    localparam logic [2:0] OUT_TRUNC     = 3'd3;
    localparam logic [2:0] OUT_MALFORMED = 3'd4;

    localparam logic [6:0] WANTED_TYPE_RESET = 7'd9;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       final_byte;
    } item_t;

    typedef struct packed {
        logic [31:0] expiry_value;
        logic [2:0]  outcome;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/sspf_parser.sv
// Packet parse state and the per-item next-state logic of the subpacket walk.
`timescale 1ns / 1ps
`default_nettype none

module sspf_parser import sspf_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        advance,
    input  wire item_t       item,
    input  wire logic [6:0]  wanted_type,
    output result_t          result
);

    logic [PosWidth-1:0] pos_reg, pos_next;
    logic [PosWidth-1:0] end_reg, end_next;
    logic [2:0]          phase_reg, phase_next;
    logic [31:0]         rem_reg, rem_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic [31:0]         cap_reg, cap_next;
    logic [2:0]          pend_reg, pend_next;

    logic [19:0]         p_plus1;
    logic [19:0]         room;
    logic [31:0]         len_two;
    logic [31:0]         len_five;
    logic [31:0]         rem_dec;
    logic [2:0]          cnt_inc;
    logic [7:0]          b;
    logic [PosWidth-1:0] pos_inc;
    logic                type_hit;

    // A new subpacket needs at least three bytes of the hashed area left.
    function automatic logic [2:0] start_phase(logic [19:0] nxt, logic [PosWidth-1:0] e);
        return ((nxt + 20'd2) < {2'b00, e}) ? PH_LEN1 : PH_DONE;
    endfunction

    assign b        = item.packet_byte;
    assign p_plus1  = {2'b00, pos_reg} + 20'd1;
    assign room     = (p_plus1 <= {2'b00, end_reg}) ? ({2'b00, end_reg} - p_plus1) : 20'd0;
    assign len_two  = rem_reg + {24'd0, b};
    assign len_five = {rem_reg[23:0], b};
    assign rem_dec  = rem_reg - 32'd1;
    assign cnt_inc  = cnt_reg + 3'd1;
    assign pos_inc  = (pos_reg != PosMax) ? (pos_reg + 18'd1) : pos_reg;
    assign type_hit = ((b[6:0]) == wanted_type) && (rem_reg >= 32'd5);

    always_comb begin
        end_next   = end_reg;
        phase_next = phase_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        cap_next   = cap_reg;
        pend_next  = pend_reg;
        case (phase_reg)
            PH_HEADER: begin
                if (pos_reg == 18'd0) begin
                    if (!(b inside {8'd4, 8'd5})) begin
                        pend_next  = OUT_BAD_VER;
                        phase_next = PH_DONE;
                    end
                end else if (pos_reg == 18'd4) begin
                    end_next = {2'b00, b, 8'd0};
                end else if (pos_reg == 18'd5) begin
                    end_next   = end_reg + {10'd0, b} + 18'd6;
                    phase_next = start_phase(20'd6, end_next);
                end
            end
            PH_LEN1: begin
                if (b < 8'd192) begin
                    if (b == 8'd0 || {24'd0, b} > {12'd0, room}) begin
                        pend_next  = OUT_MALFORMED;
                        phase_next = PH_DONE;
                    end else begin
                        rem_next   = {24'd0, b};
                        phase_next = PH_TYPE;
                    end
                end else if (b < 8'd255) begin
                    rem_next   = {16'd0, (b - 8'd192), 8'd0} + 32'd192;
                    phase_next = PH_LEN2;
                end else if (({2'b00, pos_reg} + 20'd5) > {2'b00, end_reg}) begin
                    pend_next  = OUT_MALFORMED;
                    phase_next = PH_DONE;
                end else begin
                    rem_next   = 32'd0;
                    cnt_next   = 3'd0;
                    phase_next = PH_LEN5;
                end
            end
            PH_LEN2: begin
                if (len_two == 32'd0 || len_two > {12'd0, room}) begin
                    pend_next  = OUT_MALFORMED;
                    phase_next = PH_DONE;
                end else begin
                    rem_next   = len_two;
                    phase_next = PH_TYPE;
                end
            end
            PH_LEN5: begin
                rem_next = len_five;
                cnt_next = cnt_inc;
                if (cnt_inc == 3'd4) begin
                    if (len_five == 32'd0 || len_five > {12'd0, room}) begin
                        pend_next  = OUT_MALFORMED;
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_TYPE;
                    end
                end
            end
            PH_TYPE: begin
                rem_next = rem_dec;
                if (type_hit) begin
                    cap_next   = 32'd0;
                    cnt_next   = 3'd0;
                    phase_next = PH_CAPTURE;
                end else if (rem_dec == 32'd0) begin
                    phase_next = start_phase(p_plus1, end_reg);
                end else begin
                    phase_next = PH_BODY;
                end
            end
            PH_BODY: begin
                rem_next = rem_dec;
                if (rem_dec == 32'd0) begin
                    phase_next = start_phase(p_plus1, end_reg);
                end
            end
            PH_CAPTURE: begin
                cap_next = {cap_reg[23:0], b};
                cnt_next = cnt_inc;
                if (cnt_inc == 3'd4) begin
                    pend_next  = OUT_FOUND;
                    phase_next = PH_DONE;
                end
            end
            default: begin
            end
        endcase
        pos_next = pos_inc;
    end

    // The outcome sees the state as updated by the last item itself.
    always_comb begin
        if (pos_inc < 18'd6) begin
            result.outcome = OUT_TRUNC;
        end else if (pend_next == OUT_BAD_VER) begin
            result.outcome = OUT_BAD_VER;
        end else if (end_next > pos_inc) begin
            result.outcome = OUT_TRUNC;
        end else begin
            result.outcome = pend_next;
        end
        result.expiry_value = (result.outcome == OUT_FOUND) ? cap_next : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && item.final_byte)) begin
            pos_reg   <= '0;
            end_reg   <= '0;
            phase_reg <= PH_HEADER;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            cap_reg   <= '0;
            pend_reg  <= OUT_NOT_FOUND;
        end else if (advance) begin
            pos_reg   <= pos_next;
            end_reg   <= end_next;
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
            cap_reg   <= cap_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sspf_out_stage.sv
// Result register that holds one result item until the downstream side takes it.
`timescale 1ns / 1ps
`default_nettype none

module sspf_out_stage import sspf_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire result_t     result,
    output logic             can_load,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata
);

    logic    m_valid_reg;
    result_t result_reg;

    assign can_load = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, result_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sig_subpacket_expiry_finder.sv
// Top level: input register, subpacket parser and result register.
// The last byte passes through the input register; its result item is then offered from the result register.
// Throughput: one byte item per cycle; a stalled result holds the input only when
// the next byte is itself a last byte.
// Reset (aresetn low, synchronous): clears all packet state and both valid flags,
// and sets the wanted subpacket type to 9.
`timescale 1ns / 1ps
`default_nettype none

module sig_subpacket_expiry_finder import sspf_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] packet_byte
    input  wire logic        s_tlast,   // final_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // [2:0] outcome, [34:3] expiry_value
);

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic [6:0] wanted_reg;
    logic       out_can_load;
    logic       advance;
    result_t    result;

    // A buffered byte moves on unless it is a last byte facing a full result register.
    assign advance  = in_valid_reg && (!in_item_reg.final_byte || out_can_load);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wanted_reg <= WANTED_TYPE_RESET;
        end else if (cfg_wr_en) begin
            wanted_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.packet_byte <= s_tdata;
            in_item_reg.final_byte  <= s_tlast;
        end
    end

    sspf_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .item        (in_item_reg),
        .wanted_type (wanted_reg),
        .result      (result)
    );

    sspf_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && in_item_reg.final_byte),
        .result   (result),
        .can_load (out_can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
